FILE: rtl/fmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared widths, command and reply codes, and the control structs that pass
// between the lock manager's submodules.
// ----------------------------------------------------------------------------
package fmc_pkg;

  // field widths
  localparam int ID_W   = 8;
  localparam int FUNC_W = 3;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 16;

  // slot table and queue depth follow the id width
  localparam int SLOTS  = 2 ** ID_W;
  localparam int FILL_W = ID_W + 1;

  // two-level search over the slot bitmap
  localparam int LO_W   = ID_W / 2;
  localparam int HI_W   = ID_W - LO_W;
  localparam int GRP_SZ = 2 ** LO_W;
  localparam int GRPS   = 2 ** HI_W;

  // command codes
  localparam logic [FUNC_W-1:0] FN_REGISTER   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REQUEST    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNREGISTER = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd4;

  // reply codes
  localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DENY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRANT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COUNT    = 2'd3;

  // slot bitmap control
  typedef struct packed {
    logic            alloc;
    logic            free;
    logic [ID_W-1:0] id;
  } slot_cmd_t;

  typedef struct packed {
    logic            any_free;
    logic [ID_W-1:0] free_id;
    logic            in_use;
  } slot_sts_t;

  // release count control
  typedef struct packed {
    logic            inc;
    logic            clr;
    logic [ID_W-1:0] addr;
  } cnt_cmd_t;

  // waiting queue control
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] id;
  } q_cmd_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] head_id;
  } q_sts_t;

endpackage

FILE: rtl/fmc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc channel interfaces
// Valid/ready channels for command items and reply items.
// ----------------------------------------------------------------------------
interface fmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [fmc_pkg::FUNC_W-1:0] func;
  logic [fmc_pkg::ID_W-1:0]   slot_id;

  modport source (output valid, func, slot_id, input ready);
  modport sink   (input valid, func, slot_id, output ready);
endinterface

interface fmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [fmc_pkg::KIND_W-1:0] reply_kind;
  logic [fmc_pkg::ID_W-1:0]   reply_id;
  logic [fmc_pkg::CNT_W-1:0]  release_count;
  logic                       is_registered;

  modport source (output valid, reply_kind, reply_id, release_count, is_registered,
                  input ready);
  modport sink   (input valid, reply_kind, reply_id, release_count, is_registered,
                  output ready);
endinterface

FILE: rtl/fifo_mutex_coordinator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_coordinator
// Central lock manager for one critical region: slot registration, a FIFO
// of waiting requesters, a busy flag and saturating per-slot release counts.
// ----------------------------------------------------------------------------
// Each command item passes an input stage register and then the reply
// register, from which its reply is offered; commands with no reply (a
// queued request, a release that grants nothing, an unregister) simply
// retire. One item is taken every cycle as long as replies are taken; a
// waiting reply stalls the input stage. The release-count memory is read at
// acceptance and written back when the item leaves the stage register, with
// forwarding between neighboring items, so that port pair sets the pace.
// Reset clears all slots, counts and the queue.
// ----------------------------------------------------------------------------
module fifo_mutex_coordinator (
  input  logic       clk,
  input  logic       rst_n,
  fmc_in_if.sink     in_chan,
  fmc_out_if.source  out_chan
);

  // stage register
  logic                        s1_vld_r;
  logic [fmc_pkg::FUNC_W-1:0]  s1_func_r;
  logic [fmc_pkg::ID_W-1:0]    s1_pid_r;
  logic                        s1_go;
  logic                        in_acc;

  // region flag
  logic                        busy_r;
  logic                        busy_nxt;

  // reply register
  logic                        out_vld_r;
  logic [fmc_pkg::KIND_W-1:0]  out_kind_r;
  logic [fmc_pkg::ID_W-1:0]    out_id_r;
  logic [fmc_pkg::CNT_W-1:0]   out_cnt_r;
  logic                        out_reg_r;

  // reply of the current item
  logic                        res_vld;
  logic [fmc_pkg::KIND_W-1:0]  res_kind;
  logic [fmc_pkg::ID_W-1:0]    res_id;
  logic [fmc_pkg::CNT_W-1:0]   res_cnt;
  logic                        res_reg;

  fmc_pkg::slot_cmd_t          slot_cmd;
  fmc_pkg::slot_sts_t          slot_sts;
  fmc_pkg::cnt_cmd_t           cnt_cmd;
  logic [fmc_pkg::CNT_W-1:0]   cnt_cur;
  fmc_pkg::q_cmd_t             q_cmd;
  fmc_pkg::q_sts_t             q_sts;

  // handshake
  assign s1_go         = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || s1_go;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // submodules
  fmc_slot_map u_slot_map (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (slot_cmd),
    .sts   (slot_sts)
  );

  fmc_count_store u_count_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_chan.slot_id),
    .cmd     (cnt_cmd),
    .count   (cnt_cur)
  );

  fmc_wait_queue u_wait_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .sts   (q_sts)
  );

  // command decode; a free region always has an empty queue
  always_comb begin
    res_vld        = 1'b0;
    res_kind       = fmc_pkg::KIND_DENY;
    res_id         = '0;
    res_cnt        = '0;
    res_reg        = 1'b0;
    slot_cmd.alloc = 1'b0;
    slot_cmd.free  = 1'b0;
    slot_cmd.id    = s1_pid_r;
    cnt_cmd.inc    = 1'b0;
    cnt_cmd.clr    = 1'b0;
    cnt_cmd.addr   = s1_pid_r;
    q_cmd.push     = 1'b0;
    q_cmd.pop      = 1'b0;
    q_cmd.id       = s1_pid_r;
    busy_nxt       = busy_r;
    if (s1_go) begin
      case (s1_func_r)
        fmc_pkg::FN_REGISTER: begin
          res_vld = 1'b1;
          if (slot_sts.any_free) begin
            res_kind       = fmc_pkg::KIND_ASSIGNED;
            res_id         = slot_sts.free_id;
            slot_cmd.alloc = 1'b1;
          end
        end
        fmc_pkg::FN_REQUEST: begin
          if (!busy_r) begin
            // region free: grant straight away
            res_vld  = 1'b1;
            res_kind = fmc_pkg::KIND_GRANT;
            res_id   = s1_pid_r;
            busy_nxt = 1'b1;
          end else if (q_sts.full) begin
            res_vld = 1'b1;
          end else begin
            q_cmd.push = 1'b1;
          end
        end
        fmc_pkg::FN_RELEASE: begin
          cnt_cmd.inc = 1'b1;
          if (!q_sts.empty) begin
            // hand the region to the head of the queue
            res_vld   = 1'b1;
            res_kind  = fmc_pkg::KIND_GRANT;
            res_id    = q_sts.head_id;
            q_cmd.pop = 1'b1;
            busy_nxt  = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        fmc_pkg::FN_UNREGISTER: begin
          slot_cmd.free = 1'b1;
          cnt_cmd.clr   = 1'b1;
        end
        fmc_pkg::FN_QUERY: begin
          res_vld  = 1'b1;
          res_kind = fmc_pkg::KIND_COUNT;
          res_id   = s1_pid_r;
          res_cnt  = cnt_cur;
          res_reg  = slot_sts.in_use;
        end
        default: begin
          res_vld = 1'b1;
        end
      endcase
    end
  end

  // stage register and region flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_chan.func;
      s1_pid_r  <= in_chan.slot_id;
    end
  end

  // reply register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_kind_r <= res_kind;
      out_id_r   <= res_id;
      out_cnt_r  <= res_cnt;
      out_reg_r  <= res_reg;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.reply_kind    = out_kind_r;
  assign out_chan.reply_id      = out_id_r;
  assign out_chan.release_count = out_cnt_r;
  assign out_chan.is_registered = out_reg_r;

  // a free region never has anyone waiting
  a_free_means_empty: assert property (
    @(posedge clk) disable iff (!rst_n) !busy_r |-> q_sts.empty
  ) else $error("region free while requesters wait");

  // every grant leaves the region busy
  a_grant_sets_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
      (res_vld && res_kind == fmc_pkg::KIND_GRANT) |=> busy_r
  ) else $error("grant issued but region not marked busy");

  // a reply is only produced when the reply register can take it
  a_no_reply_overrun: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_vld_r && !out_chan.ready) |-> !res_vld
  ) else $error("reply overwrote one not yet taken");

endmodule

FILE: rtl/fmc_slot_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_slot_map
// Bitmap of registered client slots with a lowest-free-slot allocator.
// ----------------------------------------------------------------------------
module fmc_slot_map (
  input  logic               clk,
  input  logic               rst_n,
  input  fmc_pkg::slot_cmd_t cmd,
  output fmc_pkg::slot_sts_t sts
);

  logic [fmc_pkg::SLOTS-1:0] used_r;
  logic [fmc_pkg::SLOTS-1:0] used_nxt;
  logic [fmc_pkg::GRPS-1:0]  grp_free;
  logic [fmc_pkg::HI_W-1:0]  hi_sel;
  logic [fmc_pkg::GRP_SZ-1:0] grp_word;
  logic [fmc_pkg::LO_W-1:0]  lo_sel;

  // first group with a free slot
  always_comb begin
    grp_free = '0;
    hi_sel   = '0;
    for (int g = 0; g < fmc_pkg::GRPS; g++) begin
      grp_free[g] = ~&used_r[g*fmc_pkg::GRP_SZ +: fmc_pkg::GRP_SZ];
    end
    for (int g = fmc_pkg::GRPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        hi_sel = fmc_pkg::HI_W'(g);
      end
    end
  end

  // first free slot inside that group
  always_comb begin
    grp_word = ~used_r[{hi_sel, {fmc_pkg::LO_W{1'b0}}} +: fmc_pkg::GRP_SZ];
    lo_sel   = '0;
    for (int b = fmc_pkg::GRP_SZ - 1; b >= 0; b--) begin
      if (grp_word[b]) begin
        lo_sel = fmc_pkg::LO_W'(b);
      end
    end
  end

  assign sts.any_free = |grp_free;
  assign sts.free_id  = {hi_sel, lo_sel};
  assign sts.in_use   = used_r[cmd.id];

  // bitmap update
  always_comb begin
    used_nxt = used_r;
    if (cmd.alloc) begin
      used_nxt[{hi_sel, lo_sel}] = 1'b1;
    end
    if (cmd.free) begin
      used_nxt[cmd.id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

endmodule

FILE: rtl/fmc_count_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_count_store
// Per-slot saturating release counts: a memory read at item acceptance and
// written back on each increment, with per-entry valid bits standing for zero.
// ----------------------------------------------------------------------------
module fmc_count_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [fmc_pkg::ID_W-1:0]  rd_addr,
  input  fmc_pkg::cnt_cmd_t         cmd,
  output logic [fmc_pkg::CNT_W-1:0] count
);

  logic [fmc_pkg::CNT_W-1:0] mem [fmc_pkg::SLOTS];
  logic [fmc_pkg::SLOTS-1:0] vld_r;
  logic [fmc_pkg::CNT_W-1:0] rd_data_r;
  logic                      byp_r;
  logic [fmc_pkg::CNT_W-1:0] byp_data_r;
  logic [fmc_pkg::CNT_W-1:0] cnt_new;

  // current count of the addressed slot, forwarding the last write
  always_comb begin
    if (!vld_r[cmd.addr]) begin
      count = '0;
    end else if (byp_r) begin
      count = byp_data_r;
    end else begin
      count = rd_data_r;
    end
  end

  // saturating increment
  assign cnt_new = (count == '1) ? count : count + 1'b1;

  // memory port and read register
  always_ff @(posedge clk) begin
    if (cmd.inc) begin
      mem[cmd.addr] <= cnt_new;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      byp_r      <= cmd.inc && (cmd.addr == rd_addr);
      byp_data_r <= cnt_new;
    end
  end

  // valid bits: a slot not written since reset or unregister reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.inc) begin
      vld_r[cmd.addr] <= 1'b1;
    end else if (cmd.clr) begin
      vld_r[cmd.addr] <= 1'b0;
    end
  end

endmodule

FILE: rtl/fmc_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_wait_queue
// FIFO of waiting requester ids with a prefetched head entry.
// ----------------------------------------------------------------------------
module fmc_wait_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  fmc_pkg::q_cmd_t cmd,
  output fmc_pkg::q_sts_t sts
);

  logic [fmc_pkg::ID_W-1:0]   mem [fmc_pkg::SLOTS];
  logic [fmc_pkg::ID_W-1:0]   head_r;
  logic [fmc_pkg::ID_W-1:0]   head_nxt;
  logic [fmc_pkg::ID_W-1:0]   tail_r;
  logic [fmc_pkg::FILL_W-1:0] fill_r;
  logic [fmc_pkg::ID_W-1:0]   head_data_r;

  assign head_nxt    = cmd.pop ? head_r + 1'b1 : head_r;
  assign sts.empty   = (fill_r == '0);
  assign sts.full    = fill_r[fmc_pkg::ID_W];
  assign sts.head_id = head_data_r;

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      if (cmd.push) begin
        tail_r <= tail_r + 1'b1;
        fill_r <= fill_r + 1'b1;
      end else if (cmd.pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // storage and head prefetch, forwarding a push into an empty queue
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= cmd.id;
    end
    if (cmd.push && (tail_r == head_nxt)) begin
      head_data_r <= cmd.id;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

endmodule

FILE: sim/fifo_mutex_coordinator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_coordinator_test
// Drives command items into the lock manager and checks every reply against
// a cycle-free model of the slot table, waiting queue, region flag and
// release counts. Directed items come first, then table-full and
// queue-full phases, then a random mix.
// ----------------------------------------------------------------------------
module fifo_mutex_coordinator_test;

  // commands with no meaning in the block, answered with deny
  localparam logic [fmc_pkg::FUNC_W-1:0] FN_UNKNOWN_LO = 3'd5;
  localparam logic [fmc_pkg::FUNC_W-1:0] FN_UNKNOWN_HI = 3'd7;
  localparam logic [fmc_pkg::CNT_W-1:0]  CNT_TOP       = '1;

  typedef struct {
    logic [fmc_pkg::FUNC_W-1:0] func;
    logic [fmc_pkg::ID_W-1:0]   pid;
    int unsigned                gap;
    bit                         drain;
  } command_t;

  typedef struct packed {
    logic [fmc_pkg::KIND_W-1:0] kind;
    logic [fmc_pkg::ID_W-1:0]   id;
    logic [fmc_pkg::CNT_W-1:0]  cnt;
    logic                       is_reg;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // testbench-side copies of the block inputs, known from time zero
  logic                       drv_valid = 1'b0;
  logic [fmc_pkg::FUNC_W-1:0] drv_func = fmc_pkg::FN_QUERY;
  logic [fmc_pkg::ID_W-1:0]   drv_pid = '0;
  logic                       rcv_ready = 1'b0;

  fmc_in_if  in_if ();
  fmc_out_if out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.func    = drv_func;
  assign in_if.slot_id = drv_pid;
  assign out_if.ready  = rcv_ready;

  fifo_mutex_coordinator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #2 clk = ~clk;

  // lock manager shadow state
  logic                         slot_taken [fmc_pkg::SLOTS];
  logic [fmc_pkg::CNT_W-1:0]    release_tally [fmc_pkg::SLOTS];
  logic [fmc_pkg::ID_W-1:0]     wait_line [fmc_pkg::SLOTS];
  logic [fmc_pkg::ID_W-1:0]     line_head;
  logic [fmc_pkg::ID_W-1:0]     line_tail;
  logic [fmc_pkg::FILL_W-1:0]   line_fill;
  logic                         region_held;

  command_t    pending [$];
  reply_t      replies_due [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned items_total = 0;

  // pop the queue head into the region if it is free
  task automatic grant_waiter(output bit granted, output reply_t r);
    granted = 1'b0;
    r = '0;
    if (!region_held && line_fill != 0) begin
      r.kind = fmc_pkg::KIND_GRANT;
      r.id = wait_line[line_head];
      line_head = line_head + 1'b1;
      line_fill = line_fill - 1'b1;
      region_held = 1'b1;
      granted = 1'b1;
    end
  endtask

  // update the shadow state for one accepted command, queue its reply
  task automatic apply_command(input command_t c);
    reply_t r;
    bit     has_reply;
    int     free_slot;
    r = '0;
    has_reply = 1'b0;
    case (c.func)
      fmc_pkg::FN_REGISTER: begin
        free_slot = -1;
        for (int i = 0; i < fmc_pkg::SLOTS; i++) begin
          if (!slot_taken[i] && free_slot < 0) free_slot = i;
        end
        has_reply = 1'b1;
        if (free_slot < 0) begin
          r.kind = fmc_pkg::KIND_DENY;
        end else begin
          slot_taken[free_slot] = 1'b1;
          r.kind = fmc_pkg::KIND_ASSIGNED;
          r.id = fmc_pkg::ID_W'(free_slot);
        end
      end
      fmc_pkg::FN_REQUEST: begin
        if (line_fill == fmc_pkg::FILL_W'(fmc_pkg::SLOTS)) begin
          has_reply = 1'b1;
          r.kind = fmc_pkg::KIND_DENY;
        end else begin
          wait_line[line_tail] = c.pid;
          line_tail = line_tail + 1'b1;
          line_fill = line_fill + 1'b1;
          grant_waiter(has_reply, r);
        end
      end
      fmc_pkg::FN_RELEASE: begin
        if (release_tally[c.pid] != CNT_TOP)
          release_tally[c.pid] = release_tally[c.pid] + 1'b1;
        region_held = 1'b0;
        grant_waiter(has_reply, r);
      end
      fmc_pkg::FN_UNREGISTER: begin
        slot_taken[c.pid] = 1'b0;
        release_tally[c.pid] = '0;
      end
      fmc_pkg::FN_QUERY: begin
        has_reply = 1'b1;
        r.kind = fmc_pkg::KIND_COUNT;
        r.id = c.pid;
        r.cnt = release_tally[c.pid];
        r.is_reg = slot_taken[c.pid];
      end
      default: begin
        has_reply = 1'b1;
        r.kind = fmc_pkg::KIND_DENY;
      end
    endcase
    if (has_reply) replies_due.push_back(r);
  endtask

  // sender gaps: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ids mostly from the low, busy slots, sometimes anywhere
  function automatic logic [fmc_pkg::ID_W-1:0] pick_pid();
    if ($urandom_range(99) < 75) return fmc_pkg::ID_W'($urandom_range(15, 0));
    return fmc_pkg::ID_W'($urandom_range(fmc_pkg::SLOTS - 1, 0));
  endfunction

  task automatic add_cmd(input logic [fmc_pkg::FUNC_W-1:0] func,
                         input logic [fmc_pkg::ID_W-1:0] pid,
                         input int unsigned gap, input bit drain);
    command_t c;
    c.func = func;
    c.pid = pid;
    c.gap = gap;
    c.drain = drain;
    pending.push_back(c);
  endtask

  // command driver
  always @(posedge clk) begin : driver
    command_t    shown;
    int unsigned gap_left;
    bit          go;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      gap_left = 0;
      items_sent = 0;
      line_head = '0;
      line_tail = '0;
      line_fill = '0;
      region_held = 1'b0;
      for (int i = 0; i < fmc_pkg::SLOTS; i++) begin
        slot_taken[i] = 1'b0;
        release_tally[i] = '0;
        wait_line[i] = '0;
      end
    end else begin
      if (drv_valid && in_if.ready) begin
        apply_command(shown);
        items_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        go = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && replies_due.size() != 0)) begin
          shown = pending.pop_front();
          gap_left = shown.gap;
          go = 1'b1;
        end
        drv_valid <= go;
        if (go) begin
          drv_func <= shown.func;
          drv_pid <= shown.pid;
        end
      end
    end
  end

  // reply receiver: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    int unsigned replies_taken;
    int unsigned cycle_no;
    bit          long_hold_done;
    int unsigned roll;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      hold_left = 0;
      replies_taken = 0;
      cycle_no = 0;
      long_hold_done = 1'b0;
    end else begin
      cycle_no++;
      if (out_if.valid && rcv_ready) replies_taken++;
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if (!long_hold_done && replies_taken >= 400) begin
        long_hold_done = 1'b1;
        hold_left = 600;
        rcv_ready <= 1'b0;
      end else if ((cycle_no / 1500) % 4 == 1) begin
        rcv_ready <= 1'b1;
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          rcv_ready <= 1'b1;
        end else if (roll < 97) begin
          hold_left = $urandom_range(3, 0);
          rcv_ready <= 1'b0;
        end else begin
          hold_left = $urandom_range(40, 10);
          rcv_ready <= 1'b0;
        end
      end
    end
  end

  // reply check
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_if.valid && rcv_ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected reply: kind %0d id %0d count %0d registered %0d",
               out_if.reply_kind, out_if.reply_id, out_if.release_count,
               out_if.is_registered);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_if.reply_kind !== want.kind) begin
          $error("reply_kind: expected %0d, actual %0d", want.kind, out_if.reply_kind);
          mismatch_count++;
        end
        if (out_if.reply_id !== want.id) begin
          $error("reply_id: expected %0d, actual %0d", want.id, out_if.reply_id);
          mismatch_count++;
        end
        if (out_if.release_count !== want.cnt) begin
          $error("release_count: expected %0d, actual %0d", want.cnt,
                 out_if.release_count);
          mismatch_count++;
        end
        if (out_if.is_registered !== want.is_reg) begin
          $error("is_registered: expected %0d, actual %0d", want.is_reg,
                 out_if.is_registered);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned roll;
    bit          calm;

    // directed: fresh table, first grants, release while free, reuse
    add_cmd(fmc_pkg::FN_QUERY, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REQUEST, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REQUEST, 8'd1, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REQUEST, 8'd255, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_RELEASE, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_RELEASE, 8'd1, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_RELEASE, 8'd255, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_RELEASE, 8'd7, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_QUERY, 8'd7, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_QUERY, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_UNREGISTER, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_QUERY, 8'd0, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);
    for (int f = FN_UNKNOWN_LO; f <= FN_UNKNOWN_HI; f++)
      add_cmd(fmc_pkg::FUNC_W'(f), 8'd255, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_QUERY, 8'd255, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_REQUEST, 8'd170, idle_gap(), 1'b0);
    add_cmd(fmc_pkg::FN_RELEASE, 8'd85, idle_gap(), 1'b0);

    // fill the slot table past its end, then free and reclaim a few
    for (int i = 0; i < 260; i++)
      add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);
    for (int i = 0; i < 24; i++)
      add_cmd(fmc_pkg::FN_UNREGISTER,
              fmc_pkg::ID_W'($urandom_range(fmc_pkg::SLOTS - 1, 0)), idle_gap(), 1'b0);
    for (int i = 0; i < 26; i++)
      add_cmd(fmc_pkg::FN_REGISTER, 8'd0, idle_gap(), 1'b0);

    // queue full: hold the region, fill every entry, overflow, then drain
    add_cmd(fmc_pkg::FN_REQUEST, pick_pid(), idle_gap(), 1'b1);
    for (int i = 0; i < fmc_pkg::SLOTS + 3; i++)
      add_cmd(fmc_pkg::FN_REQUEST,
              fmc_pkg::ID_W'($urandom_range(fmc_pkg::SLOTS - 1, 0)), idle_gap(), 1'b0);
    for (int i = 0; i < fmc_pkg::SLOTS + 1; i++)
      add_cmd(fmc_pkg::FN_RELEASE, pick_pid(), $urandom_range(1, 0), 1'b0);

    // random mix, in blocks, every fourth block without sender gaps
    for (int i = 0; i < 700; i++) begin
      calm = ((i / 100) % 4 == 3);
      roll = $urandom_range(99);
      if (roll < 10)
        add_cmd(fmc_pkg::FN_REGISTER,
                fmc_pkg::ID_W'($urandom_range(fmc_pkg::SLOTS - 1, 0)),
                calm ? 0 : idle_gap(), 1'b0);
      else if (roll < 38)
        add_cmd(fmc_pkg::FN_REQUEST, pick_pid(), calm ? 0 : idle_gap(), 1'b0);
      else if (roll < 64)
        add_cmd(fmc_pkg::FN_RELEASE, pick_pid(), calm ? 0 : idle_gap(), 1'b0);
      else if (roll < 74)
        add_cmd(fmc_pkg::FN_UNREGISTER, pick_pid(), calm ? 0 : idle_gap(), 1'b0);
      else if (roll < 95)
        add_cmd(fmc_pkg::FN_QUERY, pick_pid(), calm ? 0 : idle_gap(), 1'b0);
      else
        add_cmd(fmc_pkg::FUNC_W'($urandom_range(FN_UNKNOWN_HI, FN_UNKNOWN_LO)),
                pick_pid(), calm ? 0 : idle_gap(), 1'b0);
    end
    items_total = pending.size();

    // reset, then wait for all items to go in and all replies to come out
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (items_sent != items_total) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
